// ===== sv/gmp_pkg.sv =====
package gmp_pkg;

    localparam int CFG_W = 7;
    localparam logic [CFG_W-1:0] CFG_SIZE_RESET = 7'd1;
    localparam int BEST_W = 28;

    typedef struct packed {
        logic start;
        logic has_left;
        logic has_upper;
        logic last;
    } t_cell_flags;

endpackage

// ===== sv/gated_grid_max_path_dp.sv =====
// Channel   Direction  Handshake                 Payload
// in        input      i_in_valid / o_in_ready   i_gain_count, i_barrier_count
// out       output     o_out_valid / i_out_ready o_best_total, o_reachable, o_grid_done
// cfg       input      i_cfg_wr_en               i_cfg_wr_data (grid size)
//
// One cell per cycle is sustained while the output accepts; a cell's result is registered.
// The transfer edge reads the row buffer entry for the cell's column, and the combine
// stage writes the new total back as the cell moves on, one read and one write per cycle.
// Reset clears the pipeline, the position and the grid size to one; the row buffer
// is not cleared, since an entry is used only after the row above has written it.
// A stall on the output holds the combine stage and, while it holds a cell, lowers o_in_ready.
module gated_grid_max_path_dp #(
    parameter int GRID_MAX   = 64,
    parameter int COUNT_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [gmp_pkg::CFG_W-1:0]    i_cfg_wr_data,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [COUNT_BITS-1:0]        i_gain_count,
    input  logic [COUNT_BITS-1:0]        i_barrier_count,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [gmp_pkg::BEST_W-1:0]   o_best_total,
    output logic                         o_reachable,
    output logic                         o_grid_done
);
    import gmp_pkg::*;

    localparam int IDX_W   = (GRID_MAX > 1) ? $clog2(GRID_MAX) : 1;
    localparam int TOTAL_W = COUNT_BITS + $clog2(2 * GRID_MAX);
    localparam int WORD_W  = TOTAL_W + 1;

    logic              in_fire;
    logic              s1_adv;
    logic [IDX_W-1:0]  pos_col;
    t_cell_flags       pos_flags;

    logic              r_s1_valid;
    logic [COUNT_BITS-1:0] r_s1_gain;
    logic [COUNT_BITS-1:0] r_s1_barrier;
    logic [IDX_W-1:0]  r_s1_col;
    t_cell_flags       r_s1_flags;

    logic [WORD_W-1:0] rd_word;
    logic [TOTAL_W-1:0] up_best;
    logic              up_valid;

    logic              r_left_valid;
    logic [TOTAL_W-1:0] r_left_best;

    logic              left_ok;
    logic              up_ok;
    logic              cell_ok;
    logic [TOTAL_W-1:0] pick;
    logic [TOTAL_W-1:0] cell_best;

    logic              r_out_valid;
    logic [TOTAL_W-1:0] r_out_best;
    logic              r_out_ok;
    logic              r_out_done;

    assign s1_adv     = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_adv;
    assign in_fire    = i_in_valid && o_in_ready;

    gmp_pos_seq #(
        .GRID_MAX (GRID_MAX),
        .IDX_W    (IDX_W)
    ) u_pos_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_step        (in_fire),
        .o_col         (pos_col),
        .o_flags       (pos_flags)
    );

    gmp_row_mem #(
        .DEPTH  (GRID_MAX),
        .ADDR_W (IDX_W),
        .DATA_W (WORD_W)
    ) u_row_mem (
        .i_clk     (i_clk),
        .i_rd_en   (in_fire),
        .i_rd_addr (pos_col),
        .o_rd_data (rd_word),
        .i_wr_en   (s1_adv),
        .i_wr_addr (r_s1_col),
        .i_wr_data ({cell_ok, cell_best})
    );

    assign up_valid = rd_word[WORD_W-1];
    assign up_best  = rd_word[TOTAL_W-1:0];

    // The upper entry was written when the cell one row above left the combine
    // stage, which is never later than this cell's read.
    always_comb begin
        left_ok = r_s1_flags.has_left && r_left_valid
                  && (r_left_best >= TOTAL_W'(r_s1_barrier));
        up_ok   = r_s1_flags.has_upper && up_valid
                  && (up_best >= TOTAL_W'(r_s1_barrier));
        if (r_s1_flags.start) begin
            pick = '0;
        end else if (left_ok && up_ok) begin
            pick = (up_best > r_left_best) ? up_best : r_left_best;
        end else if (up_ok) begin
            pick = up_best;
        end else begin
            pick = r_left_best;
        end
        cell_ok   = r_s1_flags.start || left_ok || up_ok;
        cell_best = cell_ok ? (pick + TOTAL_W'(r_s1_gain)) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_gain    <= i_gain_count;
            r_s1_barrier <= i_barrier_count;
            r_s1_col     <= pos_col;
            r_s1_flags   <= pos_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_valid <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_left_valid <= 1'b0;
        end else if (s1_adv) begin
            r_left_valid <= cell_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_left_best <= cell_best;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_best <= cell_best;
            r_out_ok   <= cell_ok;
            r_out_done <= r_s1_flags.last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_best_total = BEST_W'(r_out_best);
    assign o_reachable  = r_out_ok;
    assign o_grid_done  = r_out_done;

endmodule

// ===== sv/gmp_pos_seq.sv =====
module gmp_pos_seq #(
    parameter int GRID_MAX = 64,
    parameter int IDX_W    = 6
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [gmp_pkg::CFG_W-1:0]  i_cfg_wr_data,
    input  logic                       i_step,
    output logic [IDX_W-1:0]           o_col,
    output gmp_pkg::t_cell_flags       o_flags
);
    import gmp_pkg::*;

    localparam int SIDE_W = $clog2(GRID_MAX + 1);
    localparam int CMP_W  = (SIDE_W > CFG_W) ? SIDE_W : CFG_W;

    logic [CFG_W-1:0]  r_size;
    logic [IDX_W-1:0]  r_row;
    logic [IDX_W-1:0]  r_col;
    logic [IDX_W-1:0]  n_row;
    logic [IDX_W-1:0]  n_col;
    logic [SIDE_W-1:0] side;
    logic [SIDE_W-1:0] last_idx;
    logic              at_last_col;
    logic              at_last_row;

    // A size of zero acts as one and sizes above the buffer depth saturate.
    always_comb begin
        if (r_size == '0) begin
            side = SIDE_W'(1);
        end else if (CMP_W'(r_size) > CMP_W'(GRID_MAX)) begin
            side = SIDE_W'(GRID_MAX);
        end else begin
            side = SIDE_W'(r_size);
        end
    end

    assign last_idx    = side - SIDE_W'(1);
    assign at_last_col = (SIDE_W'(r_col) == last_idx);
    assign at_last_row = (SIDE_W'(r_row) == last_idx);

    assign o_col             = r_col;
    assign o_flags.start     = (r_row == '0) && (r_col == '0);
    assign o_flags.has_left  = (r_col != '0);
    assign o_flags.has_upper = (r_row != '0);
    assign o_flags.last      = at_last_row && at_last_col;

    always_comb begin
        n_row = r_row;
        n_col = r_col;
        if (at_last_row && at_last_col) begin
            n_row = '0;
            n_col = '0;
        end else if (at_last_col) begin
            n_row = r_row + IDX_W'(1);
            n_col = '0;
        end else begin
            n_col = r_col + IDX_W'(1);
        end
    end

    // Any size write restarts the grid at the top-left cell.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= CFG_SIZE_RESET;
            r_row  <= '0;
            r_col  <= '0;
        end else if (i_cfg_wr_en) begin
            r_size <= i_cfg_wr_data;
            r_row  <= '0;
            r_col  <= '0;
        end else if (i_step) begin
            r_row  <= n_row;
            r_col  <= n_col;
        end
    end

endmodule

// ===== sv/gmp_row_mem.sv =====
module gmp_row_mem #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6,
    parameter int DATA_W = 24
) (
    input  logic              i_clk,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== verif/gated_grid_max_path_dp_test.sv =====
module gated_grid_max_path_dp_test;
    import gmp_pkg::*;

    localparam int GRID_MAX        = 64;
    localparam int COUNT_BITS      = 16;
    localparam int RANDOM_CELLS    = 1100;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int REPORT_LIMIT    = 10;
    localparam int TAIL_CYCLES     = 8;

    typedef struct packed {
        logic [BEST_W-1:0] best_total;
        logic              reachable;
        logic              grid_done;
    } t_cell_result;

    typedef enum bit {ROW_CELL, ROW_SIZE} t_row_kind;

    typedef struct {
        t_row_kind   kind;
        int unsigned value;
        int unsigned barrier;
        bit          has_expect;
        int unsigned exp_best;
        bit          exp_reach;
        bit          exp_done;
    } t_directed_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_wr_en;
    logic [CFG_W-1:0]      i_cfg_wr_data;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [COUNT_BITS-1:0] i_gain_count;
    logic [COUNT_BITS-1:0] i_barrier_count;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [BEST_W-1:0]     o_best_total;
    logic                  o_reachable;
    logic                  o_grid_done;

    t_cell_result pending_cells [$];
    int           error_count   = 0;
    int           results_seen  = 0;
    int           quiet_cycles  = 0;
    bit           hold_off_req  = 1'b0;
    bit           smooth_flow   = 1'b0;

    // Path totals of the row above and of the cell to the left, plus the
    // position of the next cell and the programmed grid size.
    bit [28:0]        above_total [GRID_MAX];
    bit               above_ok    [GRID_MAX];
    bit [28:0]        left_total;
    bit               left_ok;
    int unsigned      cur_row;
    int unsigned      cur_col;
    bit [CFG_W-1:0]   size_reg    = CFG_SIZE_RESET;

    t_directed_row directed_rows [25] = '{
        '{ROW_CELL, 65535, 65535, 1'b1, 65535, 1'b1, 1'b1},
        '{ROW_CELL,     0, 65535, 1'b1,     0, 1'b1, 1'b1},
        '{ROW_SIZE,     0,     0, 1'b0,     0, 1'b0, 1'b0},
        '{ROW_CELL,  4660,     0, 1'b1,  4660, 1'b1, 1'b1},
        '{ROW_SIZE,   127,     0, 1'b0,     0, 1'b0, 1'b0},
        '{ROW_CELL,   100,     0, 1'b1,   100, 1'b1, 1'b0},
        '{ROW_CELL, 65535, 65535, 1'b1,     0, 1'b0, 1'b0},
        '{ROW_CELL,     9,   100, 1'b0,     0, 1'b0, 1'b0},
        '{ROW_SIZE,     3,     0, 1'b0,     0, 1'b0, 1'b0},
        '{ROW_CELL,    10, 65535, 1'b1,    10, 1'b1, 1'b0},
        '{ROW_CELL,     5,    10, 1'b0,     0, 1'b0, 1'b0},
        '{ROW_CELL,     1,    16, 1'b1,     0, 1'b0, 1'b0},
        '{ROW_CELL,    20,    10, 1'b0,     0, 1'b0, 1'b0},
        '{ROW_CELL,     0,    15, 1'b0,     0, 1'b0, 1'b0},
        '{ROW_CELL,     2,     0, 1'b0,     0, 1'b0, 1'b0},
        '{ROW_CELL, 65535,    30, 1'b0,     0, 1'b0, 1'b0},
        '{ROW_CELL,     1,    31, 1'b0,     0, 1'b0, 1'b0},
        '{ROW_CELL, 65535, 65535, 1'b0,     0, 1'b0, 1'b0},
        '{ROW_CELL,     7, 65535, 1'b1,     7, 1'b1, 1'b0},
        '{ROW_SIZE,     2,     0, 1'b0,     0, 1'b0, 1'b0},
        '{ROW_CELL,     4,     0, 1'b0,     0, 1'b0, 1'b0},
        '{ROW_CELL,     3,     4, 1'b0,     0, 1'b0, 1'b0},
        '{ROW_CELL,     3,     4, 1'b0,     0, 1'b0, 1'b0},
        '{ROW_CELL,     0,     7, 1'b0,     0, 1'b0, 1'b0},
        '{ROW_SIZE,     1,     0, 1'b0,     0, 1'b0, 1'b0}
    };

    gated_grid_max_path_dp #(
        .GRID_MAX   (GRID_MAX),
        .COUNT_BITS (COUNT_BITS)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_gain_count    (i_gain_count),
        .i_barrier_count (i_barrier_count),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_best_total    (o_best_total),
        .o_reachable     (o_reachable),
        .o_grid_done     (o_grid_done)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic void report_error(input string what);
        if (error_count < REPORT_LIMIT) begin
            $display("ERROR: %s", what);
        end
        error_count++;
    endfunction

    function automatic int unsigned active_side();
        if (size_reg == 0) return 1;
        if (size_reg > GRID_MAX) return GRID_MAX;
        return size_reg;
    endfunction

    function automatic void return_to_start();
        left_total = '0;
        left_ok    = 1'b0;
        cur_row    = 0;
        cur_col    = 0;
    endfunction

    function automatic void load_grid_size(input bit [CFG_W-1:0] value);
        size_reg = value;
        return_to_start();
    endfunction

    function automatic t_cell_result next_cell_total(input bit [COUNT_BITS-1:0] gain,
                                                     input bit [COUNT_BITS-1:0] barrier);
        int unsigned  side;
        int unsigned  col;
        bit [28:0]    best;
        bit [28:0]    from_above;
        bit           ok;
        bit           last;
        t_cell_result result;
        side = active_side();
        if (cur_row >= side || cur_col >= side) return_to_start();
        col  = cur_col;
        best = '0;
        ok   = 1'b0;
        if (cur_row == 0 && col == 0) begin
            best = gain;
            ok   = 1'b1;
        end else begin
            if (col > 0 && left_ok && left_total >= barrier) begin
                best = left_total + gain;
                ok   = 1'b1;
            end
            if (cur_row > 0 && above_ok[col] && above_total[col] >= barrier) begin
                from_above = above_total[col] + gain;
                if (!ok || from_above > best) best = from_above;
                ok = 1'b1;
            end
        end
        if (!ok) best = '0;
        last = (cur_row == side - 1) && (col == side - 1);
        above_total[col] = best;
        above_ok[col]    = ok;
        left_total       = best;
        left_ok          = ok;
        if (last) begin
            return_to_start();
        end else if (col + 1 >= side) begin
            cur_col = 0;
            cur_row = cur_row + 1;
        end else begin
            cur_col = col + 1;
        end
        result.best_total = best[BEST_W-1:0];
        result.reachable  = ok;
        result.grid_done  = last;
        return result;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (smooth_flow || hold_off_req) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 50);
    endfunction

    function automatic bit [COUNT_BITS-1:0] pick_gain();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2, 3: return COUNT_BITS'($urandom);
            default: return COUNT_BITS'($urandom_range(0, 4095));
        endcase
    endfunction

    // Some barriers sit at or just above a total that the next cell will see, so
    // that the at-least comparison is hit on both sides of equality.
    function automatic bit [COUNT_BITS-1:0] pick_barrier();
        bit [28:0] near;
        near = $urandom_range(0, 1) ? left_total : above_total[cur_col];
        case ($urandom_range(0, 9))
            0: return (near > 29'hFFFF) ? 16'hFFFF : near[15:0];
            1: return (near >= 29'hFFFF) ? 16'hFFFF : near[15:0] + 16'd1;
            2: return COUNT_BITS'($urandom);
            3: return '0;
            default: return COUNT_BITS'($urandom_range(0, 4095));
        endcase
    endfunction

    task automatic offer_cell(input bit [COUNT_BITS-1:0] gain,
                              input bit [COUNT_BITS-1:0] barrier,
                              input int unsigned gap,
                              input bit typed,
                              input t_cell_result typed_result);
        t_cell_result predicted;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_gain_count    <= gain;
        i_barrier_count <= barrier;
        do @(posedge i_clk); while (!o_in_ready);
        predicted = next_cell_total(gain, barrier);
        pending_cells.push_back(typed ? typed_result : predicted);
    endtask

    task automatic wait_for_drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_cells.size() != 0);
    endtask

    task automatic write_grid_size(input bit [CFG_W-1:0] value);
        wait_for_drain();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        load_grid_size(value);
    endtask

    initial begin : output_pacing
        int unsigned span;
        bit          level;
        i_out_ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_off_req) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                hold_off_req = 1'b0;
            end else begin
                if (smooth_flow) begin
                    level = 1'b1;
                    span  = 1;
                end else begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4: begin
                            level = 1'b1;
                            span  = $urandom_range(1, 40);
                        end
                        5, 6, 7, 8: begin
                            level = 1'b0;
                            span  = $urandom_range(1, 3);
                        end
                        default: begin
                            level = 1'b0;
                            span  = $urandom_range(10, 60);
                        end
                    endcase
                end
                i_out_ready <= level;
                repeat (span) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_cell_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_cells.size() == 0) begin
                report_error($sformatf(
                    "result %0d with none expected: total %0d reach %0b done %0b",
                    results_seen, o_best_total, o_reachable, o_grid_done));
            end else begin
                want = pending_cells.pop_front();
                if (o_best_total !== want.best_total) begin
                    report_error($sformatf("result %0d best_total expected %0d got %0d",
                                           results_seen, want.best_total, o_best_total));
                end
                if (o_reachable !== want.reachable) begin
                    report_error($sformatf("result %0d reachable expected %0b got %0b",
                                           results_seen, want.reachable, o_reachable));
                end
                if (o_grid_done !== want.grid_done) begin
                    report_error($sformatf("result %0d grid_done expected %0b got %0b",
                                           results_seen, want.grid_done, o_grid_done));
                end
            end
            results_seen++;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_wr_en || (i_in_valid && o_in_ready)
                || (o_out_valid && i_out_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("gated_grid_max_path_dp_test: done, errors");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int unsigned  phase;
        int unsigned  sent;
        int unsigned  side;
        int unsigned  count;
        bit [CFG_W-1:0] size_value;
        t_cell_result typed_result;
        i_rst_n         <= 1'b0;
        i_cfg_wr_en     <= 1'b0;
        i_cfg_wr_data   <= '0;
        i_in_valid      <= 1'b0;
        i_gain_count    <= '0;
        i_barrier_count <= '0;
        load_grid_size(CFG_SIZE_RESET);
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[k]) begin
            if (directed_rows[k].kind == ROW_SIZE) begin
                write_grid_size(CFG_W'(directed_rows[k].value));
            end else begin
                typed_result.best_total = BEST_W'(directed_rows[k].exp_best);
                typed_result.reachable  = directed_rows[k].exp_reach;
                typed_result.grid_done  = directed_rows[k].exp_done;
                offer_cell(COUNT_BITS'(directed_rows[k].value),
                           COUNT_BITS'(directed_rows[k].barrier),
                           pick_gap(), directed_rows[k].has_expect, typed_result);
            end
        end

        phase = 0;
        sent  = 0;
        while (sent < RANDOM_CELLS) begin
            case (phase)
                0: size_value = 7'd127;
                1: size_value = 7'd64;
                2: size_value = 7'd0;
                3: size_value = 7'd1;
                4: size_value = 7'd2;
                5: size_value = 7'd4;
                6: size_value = 7'd6;
                default: begin
                    if ($urandom_range(0, 19) == 0) size_value = CFG_W'($urandom_range(20, 127));
                    else size_value = CFG_W'($urandom_range(0, 9));
                end
            endcase
            write_grid_size(size_value);
            side = active_side();
            if (side >= 16) begin
                count = $urandom_range(side, 3 * side);
            end else begin
                count = side * side * $urandom_range(1, 4) + $urandom_range(0, side - 1);
            end
            if (phase == 5) begin
                count        = 80;
                hold_off_req = 1'b1;
            end
            if (count > RANDOM_CELLS - sent) begin
                count = RANDOM_CELLS - sent;
            end
            smooth_flow = (phase == 6);
            repeat (count) begin
                offer_cell(pick_gain(), pick_barrier(), pick_gap(), 1'b0, '0);
            end
            smooth_flow = 1'b0;
            sent += count;
            phase++;
        end

        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("gated_grid_max_path_dp_test: done, clean");
        end else begin
            $display("gated_grid_max_path_dp_test: done, errors");
        end
        $finish;
    end

endmodule
